@@ hdl/lcg48_random_source_unit_assert.svh @@
// assertion macros used by the checker file
`ifndef LCG48_RANDOM_SOURCE_UNIT_ASSERT_SVH
`define LCG48_RANDOM_SOURCE_UNIT_ASSERT_SVH

// condition holds at every edge outside reset
`define LCG48_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define LCG48_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/lcg48_pkg.sv @@
package lcg48_pkg;

  localparam int unsigned AddrW = 3;

  // multiplier constant 0x5DEECE66D split into a low word and a high part
  localparam logic [31:0] LcgMultLo = 32'hDEEC_E66D;
  localparam logic [31:0] LcgMultHi = 32'h0000_0005;
  localparam logic [47:0] LcgInc = 48'h0000_0000_000B;

  localparam logic [31:0] SeedRst = 32'h0000_0000;
  localparam logic [15:0] SeedLowRst = 16'hD31A;

  // register index taken from paddr[2]
  localparam logic RegSeed = 1'b0;
  localparam logic RegLow = 1'b1;

  // last partial-product index of each multiply pass
  localparam logic [1:0] PpLastLcg = 2'd2;
  localparam logic [1:0] PpLastScale = 2'd3;

  typedef enum logic [3:0] {
    OP_S32      = 4'd0,
    OP_U32      = 4'd1,
    OP_S16      = 4'd2,
    OP_U16      = 4'd3,
    OP_U64      = 4'd4,
    OP_S64      = 4'd5,
    OP_FRAC     = 4'd6,
    OP_RANGE_S32 = 4'd7,
    OP_RANGE_U32 = 4'd8,
    OP_RANGE_S64 = 4'd9,
    OP_RANGE_U64 = 4'd10,
    OP_COIN_A   = 4'd11,
    OP_COIN_B   = 4'd12
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_FIN,
    ST_OUT
  } st_e;

endpackage

@@ hdl/lcg48_random_source_unit.sv @@
// channel   | dir | tdata (low bit up)                    | tuser
// s_axis    | in  | low_bound[63:0], high_bound[127:64]   | opcode[3:0]
// m_axis    | out | random_value[63:0]                    | -
// apb       | in  | seed_value at 0x0, seed_low_word at 0x4
//
// one 32x32 multiplier serves every step; each partial product passes through a
// multiply state and an accumulate state, and each pass ends in a finish state
// the ranged forms follow the lcg draw with a scaling pass; U64 and S64 draw twice
// each item is accepted in the idle state and held in the output state until taken
// async active-low reset loads the state with seed 0 and low word 0xd31a
// no new item is taken until the result beat has been taken downstream
module lcg48_random_source_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [127:0]                s_axis_tdata,   // low_bound[63:0], high_bound[127:64]
  input  logic [3:0]                  s_axis_tuser,   // opcode[3:0]
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [63:0]                 m_axis_tdata,   // random_value[63:0]
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcg48_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  lcg48_pkg::st_e st_q, st_d;
  lcg48_pkg::op_e op_q, op_d;

  logic [31:0]  seed_q, seed_d;
  logic [15:0]  seed_low_q, seed_low_d;
  logic [47:0]  lcg_q, lcg_d;
  logic [63:0]  lo_q, lo_d;
  logic [63:0]  diff_q, diff_d;
  logic [63:0]  prod_q, prod_d;
  logic [111:0] acc_q, acc_d;
  logic [63:0]  res_q, res_d;
  logic [1:0]   pp_q, pp_d;
  logic         scale_q, scale_d;
  logic         draw_q, draw_d;

  logic         in_beat;
  logic         cfg_wr;
  logic         op_valid;
  logic         pp_last;
  logic         again;
  logic [31:0]  mul_a;
  logic [31:0]  mul_b;
  logic [111:0] addend;
  logic [47:0]  x_new;
  logic [63:0]  scaled;
  logic [63:0]  diff_full;
  logic [31:0]  sum32;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign op_valid = (s_axis_tuser <= 4'(lcg48_pkg::OP_COIN_B));
  assign pp_last  = scale_q ? (pp_q == lcg48_pkg::PpLastScale)
                            : (pp_q == lcg48_pkg::PpLastLcg);
  assign x_new    = acc_q[47:0];
  assign scaled   = acc_q[111:48];
  assign sum32    = lo_q[31:0] + scaled[31:0];
  assign diff_full = s_axis_tdata[127:64] - s_axis_tdata[63:0];

  // another pass follows: second draw of a 64-bit form or the range scaling
  always_comb begin
    again = 1'b0;
    if (!scale_q) begin
      case (op_q) inside
        lcg48_pkg::OP_U64, lcg48_pkg::OP_S64: again = !draw_q;
        lcg48_pkg::OP_RANGE_S32, lcg48_pkg::OP_RANGE_U32,
        lcg48_pkg::OP_RANGE_S64, lcg48_pkg::OP_RANGE_U64: again = 1'b1;
        default: again = 1'b0;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (scale_q) begin
      case (pp_q)
        2'd0: begin mul_a = diff_q[31:0];  mul_b = lcg_q[31:0]; end
        2'd1: begin mul_a = diff_q[31:0];  mul_b = {16'd0, lcg_q[47:32]}; end
        2'd2: begin mul_a = diff_q[63:32]; mul_b = lcg_q[31:0]; end
        2'd3: begin mul_a = diff_q[63:32]; mul_b = {16'd0, lcg_q[47:32]}; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else begin
      case (pp_q)
        2'd0: begin mul_a = lcg48_pkg::LcgMultLo; mul_b = lcg_q[31:0]; end
        2'd1: begin mul_a = lcg48_pkg::LcgMultLo; mul_b = {16'd0, lcg_q[47:32]}; end
        2'd2: begin mul_a = lcg48_pkg::LcgMultHi; mul_b = lcg_q[31:0]; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  // high-by-high product sits at bit 64, and fits in 48 bits
  always_comb begin
    case (pp_q)
      2'd0:    addend = {48'd0, prod_q};
      2'd3:    addend = {prod_q[47:0], 64'd0};
      default: addend = {16'd0, prod_q, 32'd0};
    endcase
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      lcg48_pkg::ST_IDLE: if (in_beat) st_d = op_valid ? lcg48_pkg::ST_MUL : lcg48_pkg::ST_OUT;
      lcg48_pkg::ST_MUL:  st_d = lcg48_pkg::ST_ACC;
      lcg48_pkg::ST_ACC:  st_d = pp_last ? lcg48_pkg::ST_FIN : lcg48_pkg::ST_MUL;
      lcg48_pkg::ST_FIN:  st_d = again ? lcg48_pkg::ST_MUL : lcg48_pkg::ST_OUT;
      lcg48_pkg::ST_OUT:  if (m_axis_tready) st_d = lcg48_pkg::ST_IDLE;
      default:            st_d = lcg48_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = (st_q == lcg48_pkg::ST_IDLE);
    m_axis_tvalid = (st_q == lcg48_pkg::ST_OUT);
    m_axis_tdata  = res_q;
    pready        = 1'b1;
    prdata        = (paddr[2] == lcg48_pkg::RegLow) ? {16'd0, seed_low_q} : seed_q;
  end

  // datapath
  always_comb begin
    op_d       = op_q;
    seed_d     = seed_q;
    seed_low_d = seed_low_q;
    lcg_d      = lcg_q;
    lo_d       = lo_q;
    diff_d     = diff_q;
    prod_d     = prod_q;
    acc_d      = acc_q;
    res_d      = res_q;
    pp_d       = pp_q;
    scale_d    = scale_q;
    draw_d     = draw_q;

    case (st_q)
      lcg48_pkg::ST_IDLE: begin
        if (in_beat) begin
          op_d    = lcg48_pkg::op_e'(s_axis_tuser);
          lo_d    = s_axis_tdata[63:0];
          acc_d   = {64'd0, lcg48_pkg::LcgInc};
          pp_d    = '0;
          scale_d = 1'b0;
          draw_d  = 1'b0;
          res_d   = '0;
          if (s_axis_tuser == 4'(lcg48_pkg::OP_RANGE_S32) ||
              s_axis_tuser == 4'(lcg48_pkg::OP_RANGE_U32)) begin
            diff_d = {32'd0, diff_full[31:0]};
          end else begin
            diff_d = diff_full;
          end
        end
      end
      lcg48_pkg::ST_MUL: begin
        prod_d = mul_a * mul_b;
      end
      lcg48_pkg::ST_ACC: begin
        acc_d = acc_q + addend;
        if (!pp_last) pp_d = pp_q + 2'd1;
      end
      lcg48_pkg::ST_FIN: begin
        pp_d = '0;
        if (scale_q) begin
          case (op_q) inside
            lcg48_pkg::OP_RANGE_S32: res_d = {{32{sum32[31]}}, sum32};
            lcg48_pkg::OP_RANGE_U32: res_d = {32'd0, sum32};
            default:                 res_d = lo_q + scaled;
          endcase
        end else begin
          lcg_d = x_new;
          case (op_q) inside
            lcg48_pkg::OP_S32: res_d = {{32{x_new[47]}}, x_new[47:16]};
            lcg48_pkg::OP_U32: res_d = {32'd0, x_new[47:16]};
            lcg48_pkg::OP_S16: res_d = {{48{x_new[47]}}, x_new[47:32]};
            lcg48_pkg::OP_U16: res_d = {48'd0, x_new[47:32]};
            lcg48_pkg::OP_U64, lcg48_pkg::OP_S64: begin
              if (!draw_q) begin
                res_d  = {x_new[47:16], 32'd0};
                draw_d = 1'b1;
                acc_d  = {64'd0, lcg48_pkg::LcgInc};
              end else begin
                res_d = {res_q[63:32], x_new[47:16]};
              end
            end
            lcg48_pkg::OP_FRAC: res_d = {16'd0, x_new};
            lcg48_pkg::OP_RANGE_S32, lcg48_pkg::OP_RANGE_U32,
            lcg48_pkg::OP_RANGE_S64, lcg48_pkg::OP_RANGE_U64: begin
              scale_d = 1'b1;
              acc_d   = '0;
            end
            lcg48_pkg::OP_COIN_A, lcg48_pkg::OP_COIN_B: res_d = {63'd0, ~x_new[47]};
            default: res_d = '0;
          endcase
        end
      end
      default: ;
    endcase

    // seed writes reload the generator
    if (cfg_wr) begin
      if (paddr[2] == lcg48_pkg::RegSeed) begin
        seed_d = pwdata;
        lcg_d  = {pwdata, seed_low_q};
      end else begin
        seed_low_d = pwdata[15:0];
        lcg_d      = {seed_q, pwdata[15:0]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= lcg48_pkg::ST_IDLE;
      seed_q     <= lcg48_pkg::SeedRst;
      seed_low_q <= lcg48_pkg::SeedLowRst;
      lcg_q      <= {lcg48_pkg::SeedRst, lcg48_pkg::SeedLowRst};
      pp_q       <= '0;
      scale_q    <= 1'b0;
      draw_q     <= 1'b0;
    end else begin
      st_q       <= st_d;
      seed_q     <= seed_d;
      seed_low_q <= seed_low_d;
      lcg_q      <= lcg_d;
      pp_q       <= pp_d;
      scale_q    <= scale_d;
      draw_q     <= draw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    lo_q   <= lo_d;
    diff_q <= diff_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
  end

endmodule

@@ hdl/lcg48_chk.sv @@
`include "lcg48_random_source_unit_assert.svh"

module lcg48_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [127:0]                s_axis_tdata,
  input logic [3:0]                  s_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [63:0]                 m_axis_tdata,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [lcg48_pkg::AddrW-1:0] paddr,
  input logic [31:0]                 pwdata,
  input logic [31:0]                 prdata,
  input logic                        pready
);

  `LCG48_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat dropped or changed while stalled")

  `LCG48_ASSERT_ALWAYS(a_one_in_flight, clk_i, rst_ni, !(m_axis_tvalid && s_axis_tready), "input taken while a result is pending")

  `LCG48_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "block not busy after an input beat")

  `LCG48_ASSERT_NEXT(a_single_result, clk_i, rst_ni, m_axis_tvalid && m_axis_tready, !m_axis_tvalid, "more than one result beat per item")

  `LCG48_ASSERT_ALWAYS(a_pready_high, clk_i, rst_ni, pready, "config port not ready")

endmodule

bind lcg48_random_source_unit lcg48_chk u_lcg48_chk (.*);
